// ----- rtl/crcfr_pkg.sv -----
`default_nettype none

package crcfr_pkg;

    localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  START_RESET = 8'hAA;

    // The word CRC unit advances eight bit steps per cycle.
    localparam int CRC_STEPS_PER_CYCLE = 8;
    localparam int CRC_CYCLES          = 32 / CRC_STEPS_PER_CYCLE;
    localparam int CRC_CNT_W           = $clog2(CRC_CYCLES + 1);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Result word: crc_ok, received_crc, computed_crc, frame_length, zero fill.
    localparam int OUT_W = 80;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_PAY,
        PH_CRC
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LEN,
        CMD_PAY,
        CMD_CRC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // Eight MSB-first steps of the CRC shift register.
    function automatic logic [31:0] crc_shift8(input logic [31:0] c);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < CRC_STEPS_PER_CYCLE; k++)
        begin
            if (r[31])
            begin
                r = {r[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[30:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/crcfr_front.sv -----
`default_nettype none

module crcfr_front
    import crcfr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    output      logic          push,
    output      cmd_t          cmd
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  cbs_reg, cbs_next;
    logic [7:0]  start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            left_reg  <= '0;
            cbs_reg   <= '0;
            start_reg <= START_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            cbs_reg   <= cbs_next;
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end
        end
    end

    // Next state: frame parsing.
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        cbs_next   = cbs_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    left_next  = rx_byte;
                    cbs_next   = '0;
                    phase_next = (rx_byte == 8'd0) ? PH_CRC : PH_PAY;
                end
                PH_PAY:
                begin
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        cbs_next   = '0;
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    cbs_next = cbs_reg + 2'd1;
                    if (cbs_reg == 2'd3)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Outputs: one command per byte that belongs to a frame.
    always_comb
    begin
        push      = 1'b0;
        cmd.kind  = CMD_LEN;
        cmd.data  = rx_byte;
        cmd.last  = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                push = 1'b0;
            end
            PH_LEN:
            begin
                push     = accept;
                cmd.kind = CMD_LEN;
            end
            PH_PAY:
            begin
                push     = accept;
                cmd.kind = CMD_PAY;
                cmd.last = (left_reg == 8'd1);
            end
            PH_CRC:
            begin
                push     = accept;
                cmd.kind = CMD_CRC;
                cmd.last = (cbs_reg == 2'd3);
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/crcfr_queue.sv -----
`default_nettype none

module crcfr_queue
    import crcfr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cmd_t          push_cmd,
    input  wire logic          pop,
    output cmd_t               head_cmd,
    output queue_status_t      status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crcfr_back.sv -----
`default_nettype none

module crcfr_back
    import crcfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire cmd_t             cmd,
    output      logic             pop,
    output      logic             m_tvalid,
    input  wire logic             m_tready,
    output      logic [OUT_W-1:0] m_tdata
);

    logic [31:0]          acc_reg, acc_next;
    logic [1:0]           biw_reg, biw_next;
    logic [31:0]          crc_reg, crc_next;
    logic [CRC_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]           len_reg, len_next;
    logic [31:0]          rx_reg, rx_next;
    logic [1:0]           cbs_reg, cbs_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    logic [31:0] crc_eff;
    logic [31:0] word;
    logic [31:0] rx_full;
    logic [31:0] computed;
    logic        word_done;
    logic        crc_free;
    logic        out_free;
    logic        can_pop;

    // The CRC unit is free to take a new word in its last shifting cycle.
    assign crc_free = (cnt_reg <= CRC_CNT_W'(1));
    assign out_free = !out_valid_reg || m_tready;
    assign crc_eff  = (cnt_reg != '0) ? crc_shift8(crc_reg) : crc_reg;
    assign word     = acc_reg | (32'(cmd.data) << {biw_reg, 3'b000});
    assign rx_full  = rx_reg | (32'(cmd.data) << {cbs_reg, 3'b000});
    assign computed = (len_reg == 8'd0) ? 32'd0 : crc_eff;
    assign word_done = (biw_reg == 2'd3) || cmd.last;

    always_comb
    begin
        unique case (cmd.kind)
            CMD_LEN: can_pop = 1'b1;
            CMD_PAY: can_pop = !word_done || crc_free;
            CMD_CRC: can_pop = !cmd.last || (crc_free && out_free);
            default: can_pop = 1'b1;
        endcase
    end

    assign pop = cmd_valid && can_pop;

    always_comb
    begin
        acc_next       = acc_reg;
        biw_next       = biw_reg;
        crc_next       = crc_eff;
        cnt_next       = (cnt_reg != '0) ? cnt_reg - CRC_CNT_W'(1) : cnt_reg;
        len_next       = len_reg;
        rx_next        = rx_reg;
        cbs_next       = cbs_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            unique case (cmd.kind)
                CMD_LEN:
                begin
                    len_next = cmd.data;
                    acc_next = '0;
                    biw_next = '0;
                    crc_next = CRC_INIT;
                    cnt_next = '0;
                    rx_next  = '0;
                    cbs_next = '0;
                end
                CMD_PAY:
                begin
                    if (word_done)
                    begin
                        crc_next = crc_eff ^ word;
                        cnt_next = CRC_CNT_W'(CRC_CYCLES);
                        acc_next = '0;
                        biw_next = '0;
                    end
                    else
                    begin
                        acc_next = word;
                        biw_next = biw_reg + 2'd1;
                    end
                end
                CMD_CRC:
                begin
                    rx_next  = rx_full;
                    cbs_next = cbs_reg + 2'd1;
                    if (cmd.last)
                    begin
                        cbs_next       = '0;
                        out_valid_next = 1'b1;
                        out_data_next  = {7'd0, len_reg, computed, rx_full,
                                          (rx_full == computed)};
                    end
                end
                default:
                begin
                    rx_next = rx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            biw_reg       <= '0;
            crc_reg       <= CRC_INIT;
            cnt_reg       <= '0;
            len_reg       <= '0;
            rx_reg        <= '0;
            cbs_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            biw_reg       <= biw_next;
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            rx_reg        <= rx_next;
            cbs_reg       <= cbs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/crc_framed_byte_receiver.sv -----
// Channel      Dir  Width  Contents
// s_axis       in   8      tdata[7:0] = rx_byte
// m_axis       out  80     tdata = crc_ok, received_crc, computed_crc, frame_length
// cfg          in   8      cfg_wr_data = start_byte, written when cfg_wr_en is high
//
// One byte transfer per cycle while whole words go through. Each byte crosses the
// front parser into a two-entry command queue, and the back engine pops it from
// there, so m_tvalid rises at the earliest once the last CRC byte transfer has
// passed the queue entry and the back engine's output register. The word CRC unit
// advances eight bit steps a cycle and overlaps with the next word. A payload
// that ends in a partial word one to three bytes after a full word holds the back
// engine until the unit is free, which stops input transfers once the queue fills.
// Reset is asynchronous and active low; there is no clearing pass.
// A stalled result holds in its output register while input transfers go on
// until the command queue fills.
`default_nettype none

module crc_framed_byte_receiver
    import crcfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input stream. tdata fields from bit 0: rx_byte[7:0].
    input  wire logic             s_tvalid,
    output      logic             s_tready,
    input  wire logic [7:0]       s_tdata,
    // Result stream. tdata fields from bit 0: crc_ok[0], received_crc[32:1],
    // computed_crc[64:33], frame_length[72:65], zero fill [79:73].
    output      logic             m_tvalid,
    input  wire logic             m_tready,
    output      logic [OUT_W-1:0] m_tdata,
    // Start byte register.
    input  wire logic             cfg_wr_en,
    input  wire logic [7:0]       cfg_wr_data
);

    logic          accept;
    logic          push;
    logic          pop;
    cmd_t          front_cmd;
    cmd_t          head_cmd;
    queue_status_t q_status;

    // The front only needs room in the queue; the back drains it on its own.
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Front: hunts for the start byte and tags each frame byte as a length,
    // payload or CRC byte, marking the last payload and last CRC byte.
    crcfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .push        (push),
        .cmd         (front_cmd)
    );

    // The queue lets the front keep taking bytes while the back waits on a
    // full output register or a busy CRC unit.
    crcfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Back: packs payload bytes into words, runs the CRC, assembles the
    // received CRC and delivers the verdict through its output register.
    crcfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_status.valid),
        .cmd       (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/crcfr_checker.sv -----
`default_nettype none

module crcfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The verdict agrees with the two CRCs it carries.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[32:1] == m_tdata[64:33])))
        else $error("crc_ok does not match the CRC fields");

    // An empty payload reports a computed CRC of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[72:65] == 8'd0) |-> (m_tdata[64:33] == 32'd0))
        else $error("empty frame with nonzero computed CRC");

    // The fill bits above the length stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[79:73] == 7'd0))
        else $error("nonzero fill bits in result");

endmodule

bind crc_framed_byte_receiver crcfr_checker u_crcfr_checker (.*);

`default_nettype wire

// ----- dv/crc_framed_byte_receiver_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the framed byte receiver. Frames are built here with
// their own CRC, sent one byte per transfer on the input stream, and every byte
// that is taken is also run through a local copy of the receiver's framing and
// CRC logic. Each verdict that leaves the block is matched field by field
// against the oldest verdict the local copy has queued.
module crc_framed_byte_receiver_tb;

    import crcfr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    // Cycles that leave the block empty once no verdict is pending: the front
    // parser, the two-entry command queue and one word of the CRC unit.
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int MAX_GAP       = 14;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_BYTES  = 1200;

    // One verdict as it appears on the result stream.
    typedef struct packed {
        logic        ok;
        logic [31:0] rx_crc;
        logic [31:0] calc_crc;
        logic [7:0]  len;
    } verdict_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_wr_en;
    logic [7:0]       cfg_wr_data;

    crc_framed_byte_receiver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Local copy of the receiver state, advanced once per accepted byte.
    logic [7:0]  start_value;
    phase_t      rx_phase;
    logic [7:0]  frame_len;
    logic [7:0]  bytes_remaining;
    logic [31:0] word_acc;
    logic [1:0]  word_fill;
    logic [31:0] crc_acc;
    logic [31:0] crc_in_frame;
    logic [1:0]  crc_bytes_in;

    // Verdicts that the block still owes, oldest first.
    verdict_t pending_verdicts[$];

    // Idling switches; cleared for stretches of back-to-back traffic.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    int bytes_sent     = 0;
    int frames_sent    = 0;
    int cfg_writes     = 0;
    int verdicts_seen  = 0;
    int verdicts_good  = 0;
    int drain_pauses   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d verdicts pending", cycle_count,
                     pending_verdicts.size());
            $display("FAILURE");
            $finish;
        end
    end

    // One MSB-first CRC-32 update over a whole 32-bit word.
    function automatic logic [31:0] crc32_word_step(input logic [31:0] crc,
                                                    input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int k = 0; k < 32; k++)
        begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Advance the local receiver state by one accepted byte and queue the
    // verdict when the byte completes a frame.
    task automatic predict_rx_byte(input logic [7:0] b);
        verdict_t v;
        logic [31:0] computed;
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == start_value)
                begin
                    rx_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                frame_len       = b;
                bytes_remaining = b;
                word_acc        = '0;
                word_fill       = '0;
                crc_acc         = CRC_INIT;
                crc_in_frame    = '0;
                crc_bytes_in    = '0;
                // An empty payload skips straight to the CRC bytes.
                rx_phase = (b == 8'd0) ? PH_CRC : PH_PAY;
            end
            PH_PAY:
            begin
                word_acc  = word_acc | ({24'd0, b} << (8 * word_fill));
                word_fill = word_fill + 2'd1;
                if (word_fill == 2'd0)
                begin
                    crc_acc  = crc32_word_step(crc_acc, word_acc);
                    word_acc = '0;
                end
                bytes_remaining = bytes_remaining - 8'd1;
                if (bytes_remaining == 8'd0)
                begin
                    // A trailing partial word goes in zero padded.
                    if (word_fill != 2'd0)
                    begin
                        crc_acc   = crc32_word_step(crc_acc, word_acc);
                        word_acc  = '0;
                        word_fill = '0;
                    end
                    crc_in_frame = '0;
                    crc_bytes_in = '0;
                    rx_phase     = PH_CRC;
                end
            end
            default:
            begin
                crc_in_frame = crc_in_frame | ({24'd0, b} << (8 * crc_bytes_in));
                if (crc_bytes_in != 2'd3)
                begin
                    crc_bytes_in = crc_bytes_in + 2'd1;
                end
                else
                begin
                    computed   = (frame_len == 8'd0) ? 32'd0 : crc_acc;
                    v.ok       = (crc_in_frame == computed);
                    v.rx_crc   = crc_in_frame;
                    v.calc_crc = computed;
                    v.len      = frame_len;
                    pending_verdicts.push_back(v);
                    crc_bytes_in = '0;
                    rx_phase     = PH_HUNT;
                end
            end
        endcase
    endtask

    // Verdict checker: every result transfer is compared with the oldest
    // expectation. The first few failures are printed in full.
    always @(posedge clk)
    begin : check_verdicts
        verdict_t got;
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ok       = m_tdata[0];
            got.rx_crc   = m_tdata[32:1];
            got.calc_crc = m_tdata[64:33];
            got.len      = m_tdata[72:65];
            verdicts_seen = verdicts_seen + 1;
            if (got.ok)
            begin
                verdicts_good = verdicts_good + 1;
            end
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected verdict ok=%0b rx_crc=%h calc_crc=%h len=%0d",
                             $realtime, got.ok, got.rx_crc, got.calc_crc, got.len);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.ok !== want.ok || got.rx_crc !== want.rx_crc
                    || got.calc_crc !== want.calc_crc || got.len !== want.len)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: verdict mismatch", $realtime);
                        $display("    expected ok=%0b rx_crc=%h calc_crc=%h len=%0d",
                                 want.ok, want.rx_crc, want.calc_crc, want.len);
                        $display("    actual   ok=%0b rx_crc=%h calc_crc=%h len=%0d",
                                 got.ok, got.rx_crc, got.calc_crc, got.len);
                    end
                end
            end
        end
    end

    // Result side: before each transfer m_tready may drop for a random stall.
    initial
    begin : verdict_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Send one byte. The valid line stays high after the transfer, so a caller
    // that pauses must lower it first (stop_sending).
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent = bytes_sent + 1;
        predict_rx_byte(b);
    endtask

    task automatic stop_sending();
        @(negedge clk) s_tvalid <= 1'b0;
    endtask

    // Hold the input until every verdict has arrived and the block is empty.
    task automatic drain_verdicts();
        stop_sending();
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Start byte writes happen only with the block drained.
    task automatic write_start_byte(input logic [7:0] value);
        drain_verdicts();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk) cfg_wr_en <= 1'b0;
        start_value = value;
        cfg_writes  = cfg_writes + 1;
    endtask

    // Build one frame with the current start byte and send it. A negative
    // fill gives random payload with the start byte mixed in now and then.
    // The CRC is correct unless crc_good is clear, in which case one bit is
    // flipped. The last drop_tail bytes are left out to break the frame.
    task automatic send_frame(input logic [7:0] len, input bit crc_good, input int fill,
                              input int drop_tail);
        logic [7:0]  frame_buf [0:262];
        logic [7:0]  b;
        logic [31:0] crc;
        logic [31:0] word;
        int          n;
        crc  = CRC_INIT;
        word = '0;
        frame_buf[0] = start_value;
        frame_buf[1] = len;
        for (int i = 0; i < len; i++)
        begin
            if (fill >= 0)
            begin
                b = fill[7:0];
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                b = start_value;
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
            end
            frame_buf[2 + i] = b;
            word = word | ({24'd0, b} << (8 * (i % 4)));
            if (i % 4 == 3 || i == len - 1)
            begin
                crc  = crc32_word_step(crc, word);
                word = '0;
            end
        end
        if (len == 8'd0)
        begin
            crc = '0;
        end
        if (!crc_good)
        begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        for (int i = 0; i < 4; i++)
        begin
            frame_buf[2 + len + i] = crc[8 * i +: 8];
        end
        n = 6 + len - drop_tail;
        for (int i = 0; i < n; i++)
        begin
            send_byte(frame_buf[i]);
        end
        frames_sent = frames_sent + 1;
    endtask

    // Short frames around the edges: an empty payload, a single byte that equals
    // the start byte, and a full word of ones and an empty payload with wrong CRCs.
    task automatic test_basic_frames();
        send_frame(8'd0, 1'b1, 0, 0);
        send_byte(8'h00);
        send_frame(8'd1, 1'b1, start_value, 0);
        send_frame(8'd4, 1'b0, 8'hFF, 0);
        send_frame(8'd0, 1'b0, 0, 0);
    endtask

    // Start byte register at both extremes, then a change in the middle of a
    // frame, which only takes effect at the next hunt.
    task automatic test_start_byte_register();
        write_start_byte(8'h00);
        send_byte(8'h01);
        send_frame(8'd3, 1'b1, -1, 0);
        write_start_byte(8'hFF);
        send_frame(8'd5, 1'b1, 8'hFF, 0);
        // Start a frame, stop after its first payload byte, and move the
        // start byte while the frame is still open.
        send_frame(8'd3, 1'b1, 8'h5A, 6);
        write_start_byte(8'h3C);
        for (int i = 0; i < 6; i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        // The old start byte is now just noise.
        send_byte(8'hFF);
        send_frame(8'd2, 1'b1, -1, 0);
        write_start_byte(START_RESET);
    endtask

    // Longest payload the length byte allows.
    task automatic test_long_frame();
        send_frame(8'd255, 1'b1, -1, 0);
        send_frame(8'd255, 1'b0, -1, 0);
    endtask

    // Mostly well-formed frames with random content and length, mixed with
    // noise, bad CRCs, cut-off frames, drain pauses and start byte changes.
    task automatic test_random_traffic(input int target_bytes);
        int          sel;
        int          stop_at;
        logic [7:0]  len;
        stop_at = bytes_sent + target_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tx_idle_on = !tx_idle_on;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                rx_idle_on = !rx_idle_on;
            end
            if ($urandom_range(0, 49) == 0)
            begin
                len = 8'($urandom_range(13, 255));
            end
            else
            begin
                len = 8'($urandom_range(0, 12));
            end
            sel = $urandom_range(0, 99);
            if (sel < 72)
            begin
                send_frame(len, 1'b1, -1, 0);
            end
            else if (sel < 84)
            begin
                send_frame(len, 1'b0, -1, 0);
            end
            else if (sel < 91)
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (sel < 96)
            begin
                send_frame(len, 1'b1, -1, $urandom_range(1, 5));
            end
            else if (sel < 98)
            begin
                drain_verdicts();
                drain_pauses = drain_pauses + 1;
            end
            else
            begin
                write_start_byte(8'($urandom_range(0, 255)));
            end
        end
        // At least one full drain regardless of the draws above.
        drain_verdicts();
        drain_pauses = drain_pauses + 1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        start_value     = START_RESET;
        rx_phase        = PH_HUNT;
        frame_len       = '0;
        bytes_remaining = '0;
        word_acc        = '0;
        word_fill       = '0;
        crc_acc         = CRC_INIT;
        crc_in_frame    = '0;
        crc_bytes_in    = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_basic_frames();
        test_start_byte_register();
        test_long_frame();
        test_random_traffic(RANDOM_BYTES);

        stop_sending();
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d frames, %0d start byte writes, %0d drain pauses",
                 bytes_sent, frames_sent, cfg_writes, drain_pauses);
        $display("Checked %0d verdicts (%0d CRC matches), %0d mismatches",
                 verdicts_seen, verdicts_good, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
